### rtl/dwvd_pkg.sv
// ----------------------------------------------------------------------------
// dwvd_pkg
// Shared types and codes of the bounded double-ended list with value delete.
// ----------------------------------------------------------------------------
package dwvd_pkg;

    // Default ring size
    localparam int CAPACITY_DEF = 32;

    // Fixed field widths
    localparam int MODE_W  = 4;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 6;
    localparam int KIND_W  = 3;

    // Command codes
    localparam logic [MODE_W-1:0] MODE_ADD_FRONT = 4'd0;
    localparam logic [MODE_W-1:0] MODE_ADD_BACK  = 4'd1;
    localparam logic [MODE_W-1:0] MODE_DEL_FRONT = 4'd2;
    localparam logic [MODE_W-1:0] MODE_DEL_BACK  = 4'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR     = 4'd4;
    localparam logic [MODE_W-1:0] MODE_DEL_VALUE = 4'd5;
    localparam logic [MODE_W-1:0] MODE_EMIT_ALL  = 4'd6;
    localparam logic [MODE_W-1:0] MODE_EMIT_FIRST = 4'd7;
    localparam logic [MODE_W-1:0] MODE_EMIT_LAST = 4'd8;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ENTRY = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NONE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DONE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FULL  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 3'd4;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT,
        ST_STATUS
    } state_t;

    // One result item
    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } res_t;

    // Store port strobes
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_cmd_t;

endpackage

### rtl/dwvd_store.sv
// ----------------------------------------------------------------------------
// dwvd_store
// Entry ring storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dwvd_store #(
    parameter int CAPACITY = dwvd_pkg::CAPACITY_DEF
) (
    input  logic                                 aclk,
    input  dwvd_pkg::mem_cmd_t                   cmd,
    input  logic [$clog2(CAPACITY)-1:0]          wr_addr,
    input  logic signed [dwvd_pkg::VALUE_W-1:0]  wr_data,
    input  logic [$clog2(CAPACITY)-1:0]          rd_addr,
    output logic signed [dwvd_pkg::VALUE_W-1:0]  rd_data
);

    logic signed [dwvd_pkg::VALUE_W-1:0] mem [CAPACITY];

    // Write port
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/dwvd_ring.sv
// ----------------------------------------------------------------------------
// dwvd_ring
// Shared ring address adder: slot plus offset, wrapped once at the capacity.
// ----------------------------------------------------------------------------
module dwvd_ring #(
    parameter int CAPACITY = dwvd_pkg::CAPACITY_DEF
) (
    input  logic [$clog2(CAPACITY)-1:0]   base,
    input  logic [$clog2(CAPACITY+1)-1:0] offs,
    output logic [$clog2(CAPACITY)-1:0]   sum
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;

    logic [SW-1:0] wide;

    // base < capacity and offs <= capacity, so one subtract is enough
    always_comb begin
        wide = SW'(base) + SW'(offs);
        if (wide >= SW'(CAPACITY)) begin
            sum = AW'(wide - SW'(CAPACITY));
        end else begin
            sum = AW'(wide);
        end
    end

endmodule

### rtl/dwvd_ctrl.sv
// ----------------------------------------------------------------------------
// dwvd_ctrl
// Command sequencer: list pointers, value-delete compaction walk and entry
// emission, all driving the single store port pair and the ring adder.
// ----------------------------------------------------------------------------
module dwvd_ctrl #(
    parameter int CAPACITY = dwvd_pkg::CAPACITY_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [dwvd_pkg::MODE_W-1:0]          s_mode,
    input  logic signed [dwvd_pkg::VALUE_W-1:0]  s_value,
    input  logic [dwvd_pkg::COUNT_W-1:0]         s_count,
    output logic                                 res_valid,
    output dwvd_pkg::res_t                       res,
    input  logic                                 res_ready,
    output dwvd_pkg::mem_cmd_t                   cmd,
    output logic [$clog2(CAPACITY)-1:0]          wr_addr,
    output logic signed [dwvd_pkg::VALUE_W-1:0]  wr_data,
    output logic [$clog2(CAPACITY)-1:0]          rd_addr,
    input  logic signed [dwvd_pkg::VALUE_W-1:0]  rd_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int NW = (CW > dwvd_pkg::COUNT_W) ? CW : dwvd_pkg::COUNT_W;
    localparam int SW = CW + 1;

    dwvd_pkg::state_t state_reg, state_next;

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] rd_slot_reg, rd_slot_next;
    logic [AW-1:0] wr_slot_reg, wr_slot_next;
    logic [CW-1:0] left_reg, left_next;
    logic [CW-1:0] wr_cnt_reg, wr_cnt_next;
    logic          pend_reg, pend_next;
    logic signed [dwvd_pkg::VALUE_W-1:0] val_reg, val_next;
    logic [dwvd_pkg::KIND_W-1:0]         kind_reg, kind_next;

    logic          is_full;
    logic          is_empty;
    logic [CW-1:0] first_n;
    logic [CW-1:0] emit_n;
    logic [AW-1:0] wr_inc;
    logic [AW-1:0] ring_base;
    logic [CW-1:0] ring_offs;
    logic [AW-1:0] ring_sum;
    logic          issue;
    logic          fire;
    logic [SW-1:0] scan_sum;

    // List status and saturated count
    always_comb begin
        is_full  = (count_reg == CW'(CAPACITY));
        is_empty = (count_reg == '0);
        if (NW'(s_count) < NW'(count_reg)) begin
            first_n = CW'(s_count);
        end else begin
            first_n = count_reg;
        end
        emit_n = (s_mode == dwvd_pkg::MODE_EMIT_ALL) ? count_reg : first_n;
        wr_inc = (wr_slot_reg == AW'(CAPACITY - 1)) ? '0 : wr_slot_reg + AW'(1);
    end

    // Ring adder operand select
    always_comb begin
        ring_base = head_reg;
        ring_offs = '0;
        if (state_reg == dwvd_pkg::ST_IDLE) begin
            case (s_mode)
                dwvd_pkg::MODE_ADD_FRONT: ring_offs = CW'(CAPACITY - 1);
                dwvd_pkg::MODE_ADD_BACK:  ring_offs = count_reg;
                dwvd_pkg::MODE_DEL_FRONT: ring_offs = CW'(1);
                dwvd_pkg::MODE_EMIT_LAST: ring_offs = count_reg - first_n;
                default:                  ring_offs = '0;
            endcase
        end else begin
            ring_base = rd_slot_reg;
            ring_offs = CW'(1);
        end
    end

    dwvd_ring #(
        .CAPACITY (CAPACITY)
    ) u_ring (
        .base (ring_base),
        .offs (ring_offs),
        .sum  (ring_sum)
    );

    assign s_ready = (state_reg == dwvd_pkg::ST_IDLE);
    assign fire    = pend_reg && res_ready;
    assign issue   = (left_reg != '0) && (!pend_reg || res_ready);

    // Sequencer next state and outputs
    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        rd_slot_next = rd_slot_reg;
        wr_slot_next = wr_slot_reg;
        left_next    = left_reg;
        wr_cnt_next  = wr_cnt_reg;
        pend_next    = pend_reg;
        val_next     = val_reg;
        kind_next    = kind_reg;
        cmd          = '0;
        wr_addr      = ring_sum;
        wr_data      = s_value;
        rd_addr      = rd_slot_reg;
        res_valid    = 1'b0;
        res.kind     = kind_reg;
        res.value    = '0;
        res.last     = 1'b1;

        case (state_reg)
            dwvd_pkg::ST_IDLE: begin
                if (s_valid) begin
                    kind_next  = dwvd_pkg::KIND_DONE;
                    state_next = dwvd_pkg::ST_STATUS;
                    case (s_mode)
                        dwvd_pkg::MODE_ADD_FRONT: begin
                            if (is_full) begin
                                kind_next = dwvd_pkg::KIND_FULL;
                            end else begin
                                cmd.wr_en  = 1'b1;
                                head_next  = ring_sum;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        dwvd_pkg::MODE_ADD_BACK: begin
                            if (is_full) begin
                                kind_next = dwvd_pkg::KIND_FULL;
                            end else begin
                                cmd.wr_en  = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        dwvd_pkg::MODE_DEL_FRONT: begin
                            if (is_empty) begin
                                kind_next = dwvd_pkg::KIND_EMPTY;
                            end else begin
                                head_next  = ring_sum;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        dwvd_pkg::MODE_DEL_BACK: begin
                            if (is_empty) begin
                                kind_next = dwvd_pkg::KIND_EMPTY;
                            end else begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        dwvd_pkg::MODE_CLEAR: begin
                            head_next  = '0;
                            count_next = '0;
                        end
                        dwvd_pkg::MODE_DEL_VALUE: begin
                            rd_slot_next = head_reg;
                            wr_slot_next = head_reg;
                            left_next    = count_reg;
                            wr_cnt_next  = '0;
                            pend_next    = 1'b0;
                            val_next     = s_value;
                            state_next   = dwvd_pkg::ST_SCAN;
                        end
                        dwvd_pkg::MODE_EMIT_ALL,
                        dwvd_pkg::MODE_EMIT_FIRST,
                        dwvd_pkg::MODE_EMIT_LAST: begin
                            if (emit_n == '0) begin
                                kind_next = dwvd_pkg::KIND_NONE;
                            end else begin
                                rd_slot_next = ring_sum;
                                left_next    = emit_n;
                                pend_next    = 1'b0;
                                state_next   = dwvd_pkg::ST_EMIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // Compaction walk: read one slot, write survivors one behind
            dwvd_pkg::ST_SCAN: begin
                wr_addr = wr_slot_reg;
                wr_data = rd_data;
                if (pend_reg && (rd_data != val_reg)) begin
                    cmd.wr_en    = 1'b1;
                    wr_slot_next = wr_inc;
                    wr_cnt_next  = wr_cnt_reg + CW'(1);
                end
                if (left_reg != '0) begin
                    cmd.rd_en    = 1'b1;
                    rd_slot_next = ring_sum;
                    left_next    = left_reg - CW'(1);
                    pend_next    = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        count_next = wr_cnt_reg;
                        state_next = dwvd_pkg::ST_STATUS;
                    end
                end
            end

            // Emission: read data register feeds the result while it waits
            dwvd_pkg::ST_EMIT: begin
                res_valid = pend_reg;
                res.kind  = dwvd_pkg::KIND_ENTRY;
                res.value = rd_data;
                res.last  = (left_reg == '0);
                if (issue) begin
                    cmd.rd_en    = 1'b1;
                    rd_slot_next = ring_sum;
                    left_next    = left_reg - CW'(1);
                    pend_next    = 1'b1;
                end else if (fire) begin
                    pend_next  = 1'b0;
                    state_next = dwvd_pkg::ST_IDLE;
                end
            end

            dwvd_pkg::ST_STATUS: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = dwvd_pkg::ST_IDLE;
                end
            end

            default: state_next = dwvd_pkg::ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dwvd_pkg::ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            left_reg  <= '0;
            wr_cnt_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            left_reg  <= left_next;
            wr_cnt_reg <= wr_cnt_next;
            pend_reg  <= pend_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        rd_slot_reg <= rd_slot_next;
        wr_slot_reg <= wr_slot_next;
        val_reg     <= val_next;
        kind_reg    <= kind_next;
    end

    assign scan_sum = SW'(wr_cnt_reg) + SW'(left_reg) + SW'(pend_reg);

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_scan_budget: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dwvd_pkg::ST_SCAN) |-> (scan_sum <= SW'(count_reg)))
        else $error("compaction wrote more entries than it read");

    a_port_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wr_en && cmd.rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write hit the same slot");

    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dwvd_pkg::ST_IDLE) |-> !res_valid)
        else $error("result offered while idle");

    a_emit_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dwvd_pkg::ST_EMIT) |=> ($stable(count_reg) && $stable(head_reg)))
        else $error("list changed during emission");

endmodule

### rtl/deque_with_value_delete.sv
// ----------------------------------------------------------------------------
// deque_with_value_delete
// Bounded double-ended list of signed 32-bit values with delete-by-value.
// ----------------------------------------------------------------------------
// The block takes one command item at a time and is not ready again until
// every result of that item has entered the output register. Adds, removes,
// clear and unknown codes pass through the status state, which puts their
// status result in the output register once it has room. Emit commands read
// the first entry into the store's read data register, then pass one entry
// per cycle to the output register while the output is taken. Delete-by-value
// walks the list slot by slot, writing survivors back, then gives its status
// result like the adds. Emits and the delete walk are paced by the single
// read port of the entry store, which the walk visits one slot per cycle.
// The store needs no clearing after reset: the block is ready as soon as
// reset is released.
module deque_with_value_delete #(
    parameter int CAPACITY = dwvd_pkg::CAPACITY_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [dwvd_pkg::MODE_W-1:0]          s_mode,
    input  logic signed [dwvd_pkg::VALUE_W-1:0]  s_value,
    input  logic [dwvd_pkg::COUNT_W-1:0]         s_count,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [dwvd_pkg::KIND_W-1:0]          m_kind,
    output logic signed [dwvd_pkg::VALUE_W-1:0]  m_entry_value,
    output logic                                 m_last
);

    localparam int AW = $clog2(CAPACITY);

    dwvd_pkg::mem_cmd_t                  cmd;
    logic [AW-1:0]                       wr_addr;
    logic signed [dwvd_pkg::VALUE_W-1:0] wr_data;
    logic [AW-1:0]                       rd_addr;
    logic signed [dwvd_pkg::VALUE_W-1:0] rd_data;
    logic                                res_valid;
    logic                                res_ready;
    dwvd_pkg::res_t                      res;

    logic                                m_valid_reg, m_valid_next;
    dwvd_pkg::res_t                      m_res_reg;

    dwvd_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_mode    (s_mode),
        .s_value   (s_value),
        .s_count   (s_count),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .cmd       (cmd),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    dwvd_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .aclk    (aclk),
        .cmd     (cmd),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Output register: loads when empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = m_res_reg.kind;
    assign m_entry_value = m_res_reg.value;
    assign m_last        = m_res_reg.last;

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded double-ended list with value delete.
// A clocked driver takes command items from a queue filled at start-up and
// offers them with random gaps. A behavioural copy of the list predicts every
// result at acceptance. A clocked monitor takes the results with random
// stalls and compares each one, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP        = dwvd_pkg::CAPACITY_DEF;
    localparam int MW         = dwvd_pkg::MODE_W;
    localparam int NW         = dwvd_pkg::COUNT_W;
    localparam int RAND_ITEMS = 410;
    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_LEN   = 150;
    localparam int TAIL_WAIT  = 60;

    // codes past the last defined command
    localparam logic [dwvd_pkg::MODE_W-1:0] MODE_UNKNOWN_LO = dwvd_pkg::MODE_EMIT_LAST + 1'b1;
    localparam logic [dwvd_pkg::MODE_W-1:0] MODE_UNKNOWN_HI = '1;

    typedef struct {
        logic [dwvd_pkg::MODE_W-1:0]         mode;
        logic signed [dwvd_pkg::VALUE_W-1:0] value;
        logic [dwvd_pkg::COUNT_W-1:0]        count;
        bit                                  drain;    // hold until no result is owed
    } cmd_item_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                                s_valid = 1'b0;
    logic                                s_ready;
    logic [dwvd_pkg::MODE_W-1:0]         s_mode  = '0;
    logic signed [dwvd_pkg::VALUE_W-1:0] s_value = '0;
    logic [dwvd_pkg::COUNT_W-1:0]        s_count = '0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic [dwvd_pkg::KIND_W-1:0]         m_kind;
    logic signed [dwvd_pkg::VALUE_W-1:0] m_entry_value;
    logic                                m_last;

    // pending commands and owed results
    cmd_item_t      pending_cmds[$];
    dwvd_pkg::res_t owed_results[$];

    // predicted list contents
    logic signed [dwvd_pkg::VALUE_W-1:0] list_ring [CAP];
    int list_head = 0;
    int list_used = 0;

    // handshake bookkeeping
    bit in_busy    = 1'b0;
    int send_gap   = 0;
    int send_calm  = 0;
    int recv_wait  = 0;
    int recv_calm  = 0;
    int hold_left  = 0;
    int idle_count = 0;

    // tallies
    int errors      = 0;
    int cmds_taken  = 0;
    int results_got = 0;
    int n_entries   = 0;
    int n_nothing   = 0;
    int n_full      = 0;
    int n_empty     = 0;

    cmd_item_t      taken_cmd;
    dwvd_pkg::res_t want;

    deque_with_value_delete #(
        .CAPACITY (CAP)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_value       (s_value),
        .s_count       (s_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_entry_value (m_entry_value),
        .m_last        (m_last)
    );

    always #6 aclk = ~aclk;

    // queue one result prediction
    task automatic owe(input logic [dwvd_pkg::KIND_W-1:0] kind,
                       input logic signed [dwvd_pkg::VALUE_W-1:0] v,
                       input logic lst);
        dwvd_pkg::res_t r;
        r.kind  = kind;
        r.value = v;
        r.last  = lst;
        owed_results.push_back(r);
    endtask

    // update the list for one command and work out its results
    task automatic apply_command(input cmd_item_t cmd);
        logic [dwvd_pkg::KIND_W-1:0]         status;
        logic signed [dwvd_pkg::VALUE_W-1:0] e;
        int n, first, wr;
        bit emitting;
        status   = dwvd_pkg::KIND_DONE;
        emitting = 1'b0;
        n        = (int'(cmd.count) < list_used) ? int'(cmd.count) : list_used;
        first    = 0;
        case (cmd.mode)
            dwvd_pkg::MODE_ADD_FRONT: begin
                if (list_used >= CAP) begin
                    status = dwvd_pkg::KIND_FULL;
                end else begin
                    list_head = (list_head + CAP - 1) % CAP;
                    list_ring[list_head] = cmd.value;
                    list_used++;
                end
            end
            dwvd_pkg::MODE_ADD_BACK: begin
                if (list_used >= CAP) begin
                    status = dwvd_pkg::KIND_FULL;
                end else begin
                    list_ring[(list_head + list_used) % CAP] = cmd.value;
                    list_used++;
                end
            end
            dwvd_pkg::MODE_DEL_FRONT: begin
                if (list_used == 0) begin
                    status = dwvd_pkg::KIND_EMPTY;
                end else begin
                    list_head = (list_head + 1) % CAP;
                    list_used--;
                end
            end
            dwvd_pkg::MODE_DEL_BACK: begin
                if (list_used == 0) status = dwvd_pkg::KIND_EMPTY;
                else list_used--;
            end
            dwvd_pkg::MODE_CLEAR: begin
                list_head = 0;
                list_used = 0;
            end
            dwvd_pkg::MODE_DEL_VALUE: begin
                // compact survivors towards the front, order kept
                wr = 0;
                for (int rd = 0; rd < list_used; rd++) begin
                    e = list_ring[(list_head + rd) % CAP];
                    if (e != cmd.value) begin
                        list_ring[(list_head + wr) % CAP] = e;
                        wr++;
                    end
                end
                list_used = wr;
            end
            dwvd_pkg::MODE_EMIT_ALL, dwvd_pkg::MODE_EMIT_FIRST,
            dwvd_pkg::MODE_EMIT_LAST: begin
                emitting = 1'b1;
                if (cmd.mode == dwvd_pkg::MODE_EMIT_ALL) n = list_used;
                if (cmd.mode == dwvd_pkg::MODE_EMIT_LAST) first = list_used - n;
                if (n == 0) begin
                    owe(dwvd_pkg::KIND_NONE, '0, 1'b1);
                    n_nothing++;
                end
                for (int i = 0; i < n; i++) begin
                    owe(dwvd_pkg::KIND_ENTRY, list_ring[(list_head + first + i) % CAP],
                        i == n - 1);
                    n_entries++;
                end
            end
            default: ;
        endcase
        if (!emitting) begin
            owe(status, '0, 1'b1);
            if (status == dwvd_pkg::KIND_FULL) n_full++;
            if (status == dwvd_pkg::KIND_EMPTY) n_empty++;
        end
    endtask

    task automatic push_cmd(input logic [dwvd_pkg::MODE_W-1:0] mode,
                            input logic signed [dwvd_pkg::VALUE_W-1:0] v,
                            input logic [dwvd_pkg::COUNT_W-1:0] cnt, input bit drain);
        cmd_item_t c;
        c.mode  = mode;
        c.value = v;
        c.count = cnt;
        c.drain = drain;
        pending_cmds.push_back(c);
    endtask

    // half the values from a small pool so that delete-by-value finds matches
    function automatic logic signed [dwvd_pkg::VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 1) == 0) return $urandom;
        case ($urandom_range(0, 3))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return -32'sd1;
            default: return 32'sd17;
        endcase
    endfunction

    function automatic logic [dwvd_pkg::COUNT_W-1:0] pick_count();
        if ($urandom_range(0, 3) == 0) return NW'($urandom_range(0, 63));
        return NW'($urandom_range(0, CAP + 2));
    endfunction

    function automatic logic [dwvd_pkg::MODE_W-1:0] pick_emit();
        case ($urandom_range(0, 2))
            0: return dwvd_pkg::MODE_EMIT_ALL;
            1: return dwvd_pkg::MODE_EMIT_FIRST;
            default: return dwvd_pkg::MODE_EMIT_LAST;
        endcase
    endfunction

    // acceptance on both channels, prediction, checking and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                taken_cmd = pending_cmds.pop_front();
                apply_command(taken_cmd);
                cmds_taken++;
                in_busy = 1'b0;
                if (send_calm > 0) begin
                    send_calm--;
                    send_gap = 0;
                end else begin
                    if ($urandom_range(0, 15) == 0) send_calm = 20;
                    send_gap = $urandom_range(0, 4);
                end
            end
            if (m_valid && m_ready) begin
                results_got++;
                if (owed_results.size() == 0) begin
                    $error("result with nothing owed: kind %0d value %0d", m_kind, m_entry_value);
                    errors++;
                end else begin
                    want = owed_results.pop_front();
                    if (m_kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, m_kind);
                        errors++;
                    end
                    if (m_entry_value !== want.value) begin
                        $error("entry_value: expected %0d, got %0d", want.value, m_entry_value);
                        errors++;
                    end
                    if (m_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, m_last);
                        errors++;
                    end
                end
                if (recv_calm > 0) begin
                    recv_calm--;
                    recv_wait = 0;
                end else begin
                    if ($urandom_range(0, 15) == 0) recv_calm = 24;
                    recv_wait = $urandom_range(0, 4);
                end
                // long back-pressure so the block fills and stalls its input
                if (results_got == 60 || results_got == 600) hold_left = HOLD_LEN;
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_count = 0;
            else idle_count++;
            if (idle_count >= IDLE_LIMIT) begin
                $display("timeout after %0d idle cycles", idle_count);
                $display("deque_with_value_delete: mismatch");
                $finish;
            end
        end
    end

    // command driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!in_busy) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_cmds.size() > 0 &&
                         !(pending_cmds[0].drain && owed_results.size() > 0)) begin
                s_valid <= 1'b1;
                s_mode  <= pending_cmds[0].mode;
                s_value <= pending_cmds[0].value;
                s_count <= pending_cmds[0].count;
                in_busy = 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (recv_wait > 0) begin
            recv_wait--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // stimulus, reset and end of run
    initial begin
        int r, n;
        bit first_ep;

        // empty list corner cases
        push_cmd(dwvd_pkg::MODE_EMIT_ALL,   '0, '0, 1'b0);
        push_cmd(dwvd_pkg::MODE_DEL_FRONT,  '0, '0, 1'b0);
        push_cmd(dwvd_pkg::MODE_DEL_BACK,   '0, '0, 1'b0);
        push_cmd(dwvd_pkg::MODE_DEL_VALUE,  '0, '0, 1'b0);
        push_cmd(dwvd_pkg::MODE_EMIT_FIRST, '0, 6'd5, 1'b0);
        push_cmd(dwvd_pkg::MODE_EMIT_LAST,  '0, '0, 1'b0);
        // extremes of the value field
        push_cmd(dwvd_pkg::MODE_ADD_FRONT,  32'sh8000_0000, '0, 1'b0);
        push_cmd(dwvd_pkg::MODE_ADD_BACK,   32'sh7fff_ffff, '0, 1'b0);
        push_cmd(dwvd_pkg::MODE_ADD_FRONT,  '0, '0, 1'b0);
        push_cmd(dwvd_pkg::MODE_ADD_BACK,   -32'sd1, '0, 1'b0);
        push_cmd(dwvd_pkg::MODE_ADD_BACK,   -32'sd1, '0, 1'b0);
        // emits: count zero, saturating count, tail slices
        push_cmd(dwvd_pkg::MODE_EMIT_ALL,   '0, '0, 1'b0);
        push_cmd(dwvd_pkg::MODE_EMIT_FIRST, '0, '0, 1'b0);
        push_cmd(dwvd_pkg::MODE_EMIT_FIRST, '0, '1, 1'b0);
        push_cmd(dwvd_pkg::MODE_EMIT_LAST,  '0, 6'd2, 1'b0);
        push_cmd(dwvd_pkg::MODE_EMIT_LAST,  '0, '1, 1'b0);
        // remove both copies of a value, then ends
        push_cmd(dwvd_pkg::MODE_DEL_VALUE,  -32'sd1, '0, 1'b0);
        push_cmd(dwvd_pkg::MODE_EMIT_ALL,   '0, '0, 1'b0);
        push_cmd(dwvd_pkg::MODE_DEL_FRONT,  '0, '0, 1'b0);
        push_cmd(dwvd_pkg::MODE_DEL_BACK,   '0, '0, 1'b0);
        // undefined codes leave the list alone
        push_cmd(MODE_UNKNOWN_LO, '1, '1, 1'b0);
        push_cmd(MODE_UNKNOWN_HI, '1, '1, 1'b0);
        push_cmd(dwvd_pkg::MODE_CLEAR,      '0, '0, 1'b0);
        push_cmd(dwvd_pkg::MODE_EMIT_ALL,   '0, '0, 1'b1);

        // random episodes, mostly well-formed fill / emit / remove runs
        first_ep = 1'b1;
        while (pending_cmds.size() < RAND_ITEMS) begin
            r = $urandom_range(0, 9);
            case (r)
                0, 1, 2: begin
                    n = $urandom_range(8, CAP + 4);
                    for (int i = 0; i < n; i++)
                        push_cmd($urandom_range(0, 1) ? dwvd_pkg::MODE_ADD_BACK
                                                      : dwvd_pkg::MODE_ADD_FRONT,
                                 pick_value(), pick_count(), first_ep && i == 0);
                end
                3, 4: begin
                    n = $urandom_range(1, 4);
                    for (int i = 0; i < n; i++)
                        push_cmd(pick_emit(), pick_value(), pick_count(), first_ep && i == 0);
                end
                5: begin
                    n = $urandom_range(1, 10);
                    for (int i = 0; i < n; i++)
                        push_cmd($urandom_range(0, 1) ? dwvd_pkg::MODE_DEL_BACK
                                                      : dwvd_pkg::MODE_DEL_FRONT,
                                 pick_value(), pick_count(), first_ep && i == 0);
                end
                6: begin
                    push_cmd(dwvd_pkg::MODE_DEL_VALUE, pick_value(), pick_count(), first_ep);
                    push_cmd(dwvd_pkg::MODE_EMIT_ALL, pick_value(), pick_count(), 1'b0);
                end
                7: begin
                    push_cmd($urandom_range(0, 2) == 0 ? dwvd_pkg::MODE_CLEAR
                                                       : dwvd_pkg::MODE_DEL_VALUE,
                             pick_value(), pick_count(), first_ep);
                    push_cmd(pick_emit(), pick_value(), pick_count(), 1'b0);
                end
                default: begin
                    // noise, any code and any field value; first item waits for quiet
                    n = $urandom_range(1, 5);
                    for (int i = 0; i < n; i++)
                        push_cmd(MW'($urandom_range(0, 15)), $urandom,
                                 NW'($urandom_range(0, 63)), i == 0);
                end
            endcase
            first_ep = 1'b0;
        end

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_cmds.size() > 0 || in_busy || owed_results.size() > 0)
            @(posedge aclk);
        repeat (TAIL_WAIT) @(posedge aclk);

        if (owed_results.size() > 0) begin
            $error("%0d results never arrived", owed_results.size());
            errors++;
        end

        $display("ran %0d commands, checked %0d results: %0d entries, %0d nothing-to-print",
                 cmds_taken, results_got, n_entries, n_nothing);
        $display("adds dropped when full: %0d, removals on empty list: %0d", n_full, n_empty);
        if (errors == 0) begin
            $display("deque_with_value_delete: match");
        end else begin
            $display("deque_with_value_delete: mismatch");
        end
        $finish;
    end

endmodule
